/* rtl/kpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package kpd_pkg;

    localparam int NUM_ROWS = 5;
    localparam int NUM_COLS = 4;
    localparam int NUM_KEYS = NUM_ROWS * NUM_COLS;

    localparam int CODE_W  = 5;
    localparam int COUNT_W = 5;
    localparam int TIME_W  = 32;
    localparam int HOLD_W  = 16;

    localparam logic [CODE_W-1:0] KEY_NONE        = 5'd18;
    localparam logic [HOLD_W-1:0] LONG_PRESS_RST  = 16'd1000;

    typedef logic [NUM_ROWS-1:0] t_rows;
    typedef logic [NUM_KEYS-1:0] t_pattern;

    typedef enum logic [1:0] {
        KIND_SHORT_PUSH    = 2'd0,
        KIND_LONG_PUSH     = 2'd1,
        KIND_SHORT_RELEASE = 2'd2,
        KIND_LONG_RELEASE  = 2'd3
    } t_kind;

    // position is col*NUM_ROWS + row
    function automatic logic [CODE_W-1:0] f_code_of_pos(input logic [4:0] pos);
        logic [CODE_W-1:0] code;
        case (pos)
            5'd0:    code = 5'd1;
            5'd1:    code = 5'd5;
            5'd2:    code = 5'd9;
            5'd3:    code = 5'd12;
            5'd4:    code = 5'd16;
            5'd5:    code = 5'd2;
            5'd6:    code = 5'd6;
            5'd7:    code = 5'd10;
            5'd8:    code = 5'd13;
            5'd9:    code = 5'd17;
            5'd10:   code = 5'd3;
            5'd11:   code = 5'd7;
            5'd12:   code = 5'd0;
            5'd13:   code = 5'd14;
            5'd15:   code = 5'd4;
            5'd16:   code = 5'd8;
            5'd17:   code = 5'd11;
            5'd18:   code = 5'd15;
            default: code = KEY_NONE;
        endcase
        return code;
    endfunction

    // pattern has exactly one bit set wherever this is used, so an or of
    // the selected table entries gives the code of that key
    function automatic logic [CODE_W-1:0] f_code_for(input t_pattern pat);
        logic [CODE_W-1:0] code;
        code = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (pat[k]) begin
                code = code | f_code_of_pos(5'(k));
            end
        end
        return code;
    endfunction

    function automatic logic [COUNT_W-1:0] f_count(input t_pattern pat);
        logic [COUNT_W-1:0] cnt;
        cnt = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            cnt = cnt + COUNT_W'(pat[k]);
        end
        return cnt;
    endfunction

endpackage

`default_nettype wire

/* rtl/keypad_press_event_detector_unit.sv */
// a scan word passes through the s1 register and then the result register
// throughput: one scan word per cycle, held back only by a stalled result
// the held pattern, change time and long flag update as the word enters the
// result register, so the next scan sees the updated values
// synchronous active-low reset clears the pipeline and key state and sets
// the long press limit to 1000 ms
`timescale 1ns / 1ps
`default_nettype none

module keypad_press_event_detector_unit
    import kpd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [HOLD_W-1:0]    i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [NUM_ROWS-1:0]  i_col0_rows,
    input  wire logic [NUM_ROWS-1:0]  i_col1_rows,
    input  wire logic [NUM_ROWS-1:0]  i_col2_rows,
    input  wire logic [NUM_ROWS-1:0]  i_col3_rows,
    input  wire logic [TIME_W-1:0]    i_now_ms,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_event_valid,
    output logic [1:0]                o_event_kind,
    output logic [CODE_W-1:0]         o_key_code,
    output logic [COUNT_W-1:0]        o_pressed_count
);

    logic [HOLD_W-1:0]  r_long_ms;
    logic               r_s1_valid;
    t_pattern           r_s1_pat;
    logic [TIME_W-1:0]  r_s1_now;
    logic               r_out_valid;
    logic               r_ev_valid;
    t_kind              r_ev_kind;
    logic [CODE_W-1:0]  r_ev_code;
    logic [COUNT_W-1:0] r_ev_count;
    t_pattern           r_held;
    logic [TIME_W-1:0]  r_change_time;
    logic               r_long_reached;

    logic               w_en;
    logic [COUNT_W-1:0] w_count;
    logic [TIME_W-1:0]  w_elapsed;
    logic               n_ev_valid;
    t_kind              n_ev_kind;
    logic [CODE_W-1:0]  n_ev_code;
    t_pattern           n_held;
    logic [TIME_W-1:0]  n_change_time;
    logic               n_long_reached;

    // the whole pipe moves unless a finished word waits on a stalled output
    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    assign w_count   = f_count(r_s1_pat);
    assign w_elapsed = r_s1_now - r_change_time;

    always_comb begin
        n_ev_valid     = 1'b0;
        n_ev_kind      = KIND_SHORT_PUSH;
        n_ev_code      = KEY_NONE;
        n_held         = r_held;
        n_change_time  = r_change_time;
        n_long_reached = r_long_reached;
        // several keys down: count only, state left alone
        if (w_count <= COUNT_W'(1)) begin
            if (r_s1_pat != r_held) begin
                n_ev_valid = 1'b1;
                if (r_s1_pat == '0) begin
                    n_ev_kind = r_long_reached ? KIND_LONG_RELEASE : KIND_SHORT_RELEASE;
                    n_ev_code = f_code_for(r_held);
                end else begin
                    n_ev_kind = KIND_SHORT_PUSH;
                    n_ev_code = f_code_for(r_s1_pat);
                end
                n_change_time  = r_s1_now;
                n_long_reached = 1'b0;
                n_held         = r_s1_pat;
            end else if (r_s1_pat != '0 && !r_long_reached) begin
                if (w_elapsed > {{(TIME_W-HOLD_W){1'b0}}, r_long_ms}) begin
                    n_ev_valid     = 1'b1;
                    n_ev_kind      = KIND_LONG_PUSH;
                    n_ev_code      = f_code_for(r_s1_pat);
                    n_long_reached = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ms      <= LONG_PRESS_RST;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_held         <= '0;
            r_change_time  <= '0;
            r_long_reached <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_long_ms <= i_cfg_data;
            end
            if (w_en) begin
                r_s1_valid  <= i_valid;
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_held         <= n_held;
                    r_change_time  <= n_change_time;
                    r_long_reached <= n_long_reached;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_pat   <= {i_col3_rows, i_col2_rows, i_col1_rows, i_col0_rows};
            r_s1_now   <= i_now_ms;
            r_ev_valid <= n_ev_valid;
            r_ev_kind  <= n_ev_kind;
            r_ev_code  <= n_ev_code;
            r_ev_count <= w_count;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_event_valid   = r_ev_valid;
    assign o_event_kind    = r_ev_kind;
    assign o_key_code      = r_ev_code;
    assign o_pressed_count = r_ev_count;

    a_no_event_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_ev_valid) |-> (r_ev_code == KEY_NONE && r_ev_kind == KIND_SHORT_PUSH))
        else $error("idle result word carries event fields");

    a_multi_key_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ev_count > COUNT_W'(1)) |-> !r_ev_valid)
        else $error("event raised with several keys down");

    a_held_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_held) <= 1)
        else $error("held pattern has more than one key");

    a_long_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ev_valid && r_ev_kind == KIND_LONG_PUSH) |-> r_long_reached)
        else $error("long push shown without long flag set");

endmodule

`default_nettype wire

/* tb/tb_keypad_press_event_detector_unit.sv */
`timescale 1ns / 1ps

module tb_keypad_press_event_detector_unit
    import kpd_pkg::*;
();

    // key code for each matrix position, position is col*5 + row
    localparam logic [CODE_W-1:0] POS_CODE [0:NUM_KEYS-1] = '{
        5'd1, 5'd5, 5'd9,  5'd12, 5'd16,
        5'd2, 5'd6, 5'd10, 5'd13, 5'd17,
        5'd3, 5'd7, 5'd0,  5'd14, 5'd18,
        5'd4, 5'd8, 5'd11, 5'd15, 5'd18
    };

    typedef struct packed {
        logic               ev;
        t_kind              kind;
        logic [CODE_W-1:0]  code;
        logic [COUNT_W-1:0] cnt;
    } t_key_event;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [HOLD_W-1:0]   i_cfg_data = '0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [NUM_ROWS-1:0] i_col0_rows = '0;
    logic [NUM_ROWS-1:0] i_col1_rows = '0;
    logic [NUM_ROWS-1:0] i_col2_rows = '0;
    logic [NUM_ROWS-1:0] i_col3_rows = '0;
    logic [TIME_W-1:0]   i_now_ms = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic                o_event_valid;
    logic [1:0]          o_event_kind;
    logic [CODE_W-1:0]   o_key_code;
    logic [COUNT_W-1:0]  o_pressed_count;

    // predictor state
    t_pattern           held_keys = '0;
    logic [TIME_W-1:0]  press_time = '0;
    logic               long_done = 1'b0;
    logic [HOLD_W-1:0]  long_limit = LONG_PRESS_RST;

    t_key_event         pending_events[$];
    int                 mismatches = 0;
    logic [TIME_W-1:0]  clock_ms = '0;

    // idling controls
    bit                 tx_on = 1'b0;
    int                 tx_gap_pct = 0;
    int                 rx_stall_pct = 0;
    int                 rx_hold_req = 0;
    int                 rx_hold_left = 0;
    int                 rx_run_left = 0;

    keypad_press_event_detector_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_col0_rows     (i_col0_rows),
        .i_col1_rows     (i_col1_rows),
        .i_col2_rows     (i_col2_rows),
        .i_col3_rows     (i_col3_rows),
        .i_now_ms        (i_now_ms),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_event_valid   (o_event_valid),
        .o_event_kind    (o_event_kind),
        .o_key_code      (o_key_code),
        .o_pressed_count (o_pressed_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [CODE_W-1:0] first_key_code(input t_pattern pat);
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (pat[k]) begin
                return POS_CODE[k];
            end
        end
        return KEY_NONE;
    endfunction

    function automatic t_key_event predict_key_event(input t_pattern pat,
                                                     input logic [TIME_W-1:0] now);
        t_key_event        r;
        int                n;
        logic [TIME_W-1:0] held_for;
        n = $countones(pat);
        r.ev = 1'b0;
        r.kind = KIND_SHORT_PUSH;
        r.code = KEY_NONE;
        r.cnt = COUNT_W'(n);
        if (n <= 1) begin
            if (pat != held_keys) begin
                r.ev = 1'b1;
                if (pat == '0) begin
                    r.kind = long_done ? KIND_LONG_RELEASE : KIND_SHORT_RELEASE;
                    r.code = first_key_code(held_keys);
                end else begin
                    r.code = first_key_code(pat);
                end
                press_time = now;
                long_done = 1'b0;
                held_keys = pat;
            end else if (pat != '0 && !long_done) begin
                // elapsed time wraps modulo 2^32
                held_for = now - press_time;
                if (held_for > {16'd0, long_limit}) begin
                    r.ev = 1'b1;
                    r.kind = KIND_LONG_PUSH;
                    r.code = first_key_code(pat);
                    long_done = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic drop_valid();
        if (tx_on) begin
            i_valid <= 1'b0;
            tx_on = 1'b0;
        end
    endtask

    // offers one scan word and waits until it is taken
    task automatic send_scan(input t_pattern pat, input logic [TIME_W-1:0] now);
        int gap;
        i_valid <= 1'b1;
        tx_on = 1'b1;
        i_col0_rows <= pat[4:0];
        i_col1_rows <= pat[9:5];
        i_col2_rows <= pat[14:10];
        i_col3_rows <= pat[19:15];
        i_now_ms <= now;
        do @(posedge i_clk); while (o_stall);
        pending_events.push_back(predict_key_event(pat, now));
        if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
            drop_valid();
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // sender pause until every result word is back
    task automatic wait_drained();
        drop_valid();
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [HOLD_W-1:0] value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        long_limit = value;
    endtask

    function automatic t_pattern key_at(input int pos);
        return t_pattern'(1) << pos;
    endfunction

    // result word checker
    always @(posedge i_clk) begin
        t_key_event want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected word, event_valid", o_event_valid, 0);
            end else begin
                want = pending_events.pop_front();
                if (o_event_valid !== want.ev)
                    report_mismatch("event_valid", o_event_valid, want.ev);
                if (o_event_kind !== want.kind)
                    report_mismatch("event_kind", o_event_kind, want.kind);
                if (o_key_code !== want.code)
                    report_mismatch("key_code", o_key_code, want.code);
                if (o_pressed_count !== want.cnt)
                    report_mismatch("pressed_count", o_pressed_count, want.cnt);
            end
        end
    end

    // receiver stall: long hold-off on request, else random runs
    always @(posedge i_clk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left > 0) begin
            i_stall <= 1'b1;
            rx_hold_left--;
        end else if (rx_run_left > 0) begin
            i_stall <= 1'b1;
            rx_run_left--;
        end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
            i_stall <= 1'b1;
            rx_run_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic test_directed_events();
        send_scan('0, 32'd0);
        send_scan(key_at(0), 32'd10);
        send_scan(key_at(0), 32'd1010);      // exactly at the limit, not long yet
        send_scan(key_at(0), 32'd1011);
        send_scan(key_at(0), 32'd5000);      // long push reported only once
        send_scan('0, 32'd5001);
        send_scan(key_at(14), 32'd5002);     // unmapped position
        send_scan(key_at(19), 32'd5003);     // direct switch, also unmapped
        send_scan(key_at(12), 32'd5004);
        send_scan('1, 32'd5005);             // every key down
        send_scan(key_at(3) | key_at(17), 32'd9000);
        send_scan('0, 32'd5010);
        // hold across the time wrap
        send_scan(key_at(9), 32'hFFFF_FF00);
        send_scan(key_at(9), 32'h0000_02E8);
        send_scan(key_at(9), 32'h0000_02E9);
        send_scan('0, 32'hFFFF_FFFF);
        send_scan(key_at(4), 32'hFFFF_FFFF);
        send_scan('0, 32'h0000_0000);
        send_scan(key_at(10) | key_at(11) | key_at(15), 32'h5555_AAAA);
    endtask

    task automatic test_limit_extremes();
        write_limit(16'd0);
        send_scan(key_at(5), 32'd100);
        send_scan(key_at(5), 32'd100);
        send_scan(key_at(5), 32'd101);
        send_scan('0, 32'd102);
        write_limit(16'hFFFF);
        send_scan(key_at(18), 32'd200);
        send_scan(key_at(18), 32'd200 + 32'd65535);
        send_scan(key_at(18), 32'd200 + 32'd65536);
        send_scan('0, 32'd200 + 32'd70000);
        wait_drained();
    endtask

    task automatic test_backpressure();
        write_limit(16'd3);
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        rx_hold_req = 80;
        for (int i = 0; i < 30; i++) begin
            clock_ms += $urandom_range(0, 3);
            send_scan((i % 5 == 4) ? t_pattern'(0) : key_at(i % 20), clock_ms);
        end
        wait_drained();
    endtask

    // mostly press, hold, maybe switch, release; some noise scans
    task automatic run_random_scans(input int n_items);
        int          sent;
        int          hold_len;
        int          span;
        t_pattern    pat;
        sent = 0;
        span = int'(long_limit) / 3 + 2;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 15) begin
                pat = {5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                       5'($urandom_range(0, 31)), 5'($urandom_range(0, 31))};
                send_scan(pat, $urandom);
                sent++;
            end else begin
                pat = key_at($urandom_range(0, NUM_KEYS - 1));
                hold_len = $urandom_range(1, 8);
                for (int i = 0; i < hold_len; i++) begin
                    case ($urandom_range(0, 9))
                        0:       clock_ms = $urandom;
                        1, 2:    clock_ms += {16'd0, long_limit} + $urandom_range(0, 2) - 1;
                        default: clock_ms += $urandom_range(0, span);
                    endcase
                    // occasional second key or a switch to another key
                    if ($urandom_range(0, 9) == 0)
                        send_scan(pat | key_at($urandom_range(0, NUM_KEYS - 1)), clock_ms);
                    else if ($urandom_range(0, 14) == 0) begin
                        pat = key_at($urandom_range(0, NUM_KEYS - 1));
                        send_scan(pat, clock_ms);
                    end else
                        send_scan(pat, clock_ms);
                    sent++;
                end
                clock_ms += $urandom_range(0, span);
                send_scan('0, clock_ms);
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        tx_gap_pct = 30;
        rx_stall_pct = 30;
        write_limit(LONG_PRESS_RST);
        run_random_scans(80);
        write_limit(16'd0);
        run_random_scans(60);
        write_limit(16'hFFFF);
        run_random_scans(60);
        // a stretch with no idling on either side
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        write_limit(16'($urandom_range(1, 64)));
        run_random_scans(80);
        tx_gap_pct = 40;
        rx_stall_pct = 40;
        write_limit(16'($urandom_range(1, 64)));
        run_random_scans(80);
        tx_gap_pct = 20;
        rx_stall_pct = 20;
        write_limit(16'($urandom));
        run_random_scans(80);
        tx_gap_pct = 0;
        rx_stall_pct = 0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_events();
        test_limit_extremes();
        test_backpressure();
        test_random_traffic();
        drop_valid();
        for (int i = 0; i < 5000 && pending_events.size() != 0; i++) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (pending_events.size() != 0)
            report_mismatch("words never returned", 0, pending_events.size());
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
